### sv/fsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

	localparam int MEM_WORDS_DEF = 4096;
	localparam int FRAC_BITS_DEF = 16;

	localparam int RATE_W  = 20;
	localparam int COUNT_W = 13;
	localparam int POS_W   = 13;
	localparam int CFG_W   = 20;
	localparam int IDX_W   = 3;

	localparam logic [RATE_W-1:0]  RATE_RESET  = 20'h10000;
	localparam logic [COUNT_W-1:0] COUNT_RESET = '0;

	localparam logic [1:0] REQ_LOAD    = 2'd0;
	localparam logic [1:0] REQ_FRAME   = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [IDX_W-1:0] CFG_ENABLE       = 3'd0;
	localparam logic [IDX_W-1:0] CFG_STEREO       = 3'd1;
	localparam logic [IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd2;
	localparam logic [IDX_W-1:0] CFG_RATE_STEP    = 3'd3;
	localparam logic [IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [11:0]        word_addr;
		logic signed [15:0] word_value;
	} req_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic [11:0]        position;
		logic               wrapped;
		logic               ended;
	} rsp_t;

endpackage

`default_nettype wire

### sv/fsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

### sv/fixed_point_sample_playback.sv
// Sample playback at a programmable rate: a FRAC_BITS fraction accumulator steps an integer
// frame position; each frame transaction returns the sample pair at the truncated position
// (mono duplicated, stereo interleaved at 2*position and 2*position+1). One transaction of
// any kind is taken every cycle unless req_stall is high; a frame result passes through the
// registered read of the sample RAM (two read ports serve a stereo pair) and the output
// register. Load and restart transactions give no result. MEM_WORDS must be a power of two;
// read addresses wrap modulo MEM_WORDS. The sample RAM is not cleared: read only words
// already loaded. Users write configuration only while no frame is in flight (unenforced).
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_sample_playback
	import fsp_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp
);

	localparam int AW   = $clog2(MEM_WORDS);
	localparam int ACCW = ((FRAC_BITS > RATE_W) ? FRAC_BITS : RATE_W) + 1;
	localparam int SUMW = ACCW + POS_W + 1;

	logic               enable_q, stereo_q, loop_q;
	logic [RATE_W-1:0]  rate_q;
	logic [COUNT_W-1:0] count_q;

	logic [POS_W-1:0]     pos_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic                 ended_q;

	logic              s1_valid, s1_play, s1_stereo, s1_wrapped, s1_ended;
	logic [POS_W-1:0]  s1_pos;
	logic              s2_valid;
	rsp_t              rsp_q;

	logic              req_acc, frame_acc, load_acc, restart_acc, s1_adv;
	logic [ACCW-1:0]   acc;
	logic [SUMW-1:0]   pos_sum;
	logic              run, at_end, play, wrap, end_next;
	logic [POS_W-1:0]  pos_next;
	logic [FRAC_BITS-1:0] frac_next;
	logic [AW-1:0]     raddr_a, raddr_b;
	logic [15:0]       rdata_a, rdata_b;

	assign s1_adv      = s1_valid && (!s2_valid || !rsp_stall);
	assign req_stall   = s1_valid && s2_valid && rsp_stall;
	assign req_acc     = req_valid && !req_stall;
	assign frame_acc   = req_acc && (req.req_type == REQ_FRAME);
	assign load_acc    = req_acc && (req.req_type == REQ_LOAD)
	                     && (32'(req.word_addr) < MEM_WORDS);
	assign restart_acc = req_acc && (req.req_type == REQ_RESTART);

	always_comb begin
		acc     = ACCW'(frac_q) + ACCW'(rate_q);
		pos_sum = SUMW'(pos_q) + SUMW'(acc >> FRAC_BITS);
		run     = enable_q && !ended_q;
		at_end  = pos_sum >= SUMW'(count_q);
		wrap    = run && at_end && loop_q;
		play    = run && (!at_end || loop_q);
		end_next  = ended_q || (run && at_end && !loop_q);
		pos_next  = play ? (wrap ? '0 : pos_sum[POS_W-1:0]) : pos_q;
		frac_next = play ? acc[FRAC_BITS-1:0] : frac_q;
		raddr_a   = stereo_q ? AW'({pos_next, 1'b0}) : AW'(pos_next);
		raddr_b   = AW'({pos_next, 1'b1});
	end

	fsp_ram #(
		.WIDTH(16),
		.DEPTH(MEM_WORDS)
	) u_ram (
		.clk     (clk),
		.we      (load_acc),
		.waddr   (AW'(req.word_addr)),
		.wdata   (req.word_value),
		.re      (frame_acc),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			stereo_q <= 1'b0;
			loop_q   <= 1'b1;
			rate_q   <= RATE_RESET;
			count_q  <= COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:       enable_q <= cfg_data[0];
				CFG_STEREO:       stereo_q <= cfg_data[0];
				CFG_LOOP_ENABLE:  loop_q   <= cfg_data[0];
				CFG_RATE_STEP:    rate_q   <= cfg_data[RATE_W-1:0];
				CFG_SAMPLE_COUNT: count_q  <= cfg_data[COUNT_W-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			frac_q  <= '0;
			ended_q <= 1'b0;
		end else if (restart_acc) begin
			pos_q   <= '0;
			frac_q  <= '0;
			ended_q <= 1'b0;
		end else if (frame_acc) begin
			pos_q   <= pos_next;
			frac_q  <= frac_next;
			ended_q <= end_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (frame_acc) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_acc) begin
			s1_play    <= play;
			s1_stereo  <= stereo_q;
			s1_wrapped <= wrap;
			s1_ended   <= end_next;
			s1_pos     <= pos_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s1_adv) begin
			s2_valid <= 1'b1;
		end else if (!rsp_stall) begin
			s2_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.left     <= s1_play ? rdata_a : '0;
			rsp_q.right    <= s1_play ? (s1_stereo ? rdata_b : rdata_a) : '0;
			rsp_q.position <= s1_pos[11:0];
			rsp_q.wrapped  <= s1_wrapped;
			rsp_q.ended    <= s1_ended;
		end
	end

	assign rsp_valid = s2_valid;
	assign rsp       = rsp_q;

	a_no_s1_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		frame_acc |-> !(s1_valid && !s1_adv))
		else $error("frame transaction accepted over a held stage-1 entry");

	a_end_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q && !restart_acc |=> ended_q)
		else $error("end flag dropped without restart");

	a_ended_silent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ended |-> (rsp.left == 16'sd0) && (rsp.right == 16'sd0))
		else $error("sound after end of playback");

	a_wrap_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.wrapped |-> (rsp.position == 12'd0) && !rsp.ended)
		else $error("wrapped frame not at start");

endmodule

`default_nettype wire
